/* hw/rtl/nhte_pkg.sv */
// nhte_pkg: shared codes, hash seed and the character fold for the name hash table engine
// no dependencies
`default_nettype none
package nhte_pkg;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [7:0]  LOWER_A   = 8'h61;
    localparam logic [7:0]  LOWER_Z   = 8'h7a;
    localparam logic [7:0]  CASE_DELTA = 8'h20;

    localparam logic [1:0] ACT_FIND   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    typedef struct packed {
        logic clearing;
        logic done;
    } t_ctl;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/name_hash_table_engine.sv */
// name_hash_table_engine: top level; front, job queue and back of the name hash table
// depends on nhte_pkg, nhte_front, nhte_queue, nhte_back
`default_nettype none
// A name enters one character per item on the slave stream (tlast on the final character);
// characters are taken one per cycle while o_s_tready is high and hashed as they arrive. The
// final character queues a job for the back, which reduces the hash to a bucket a byte at a
// time, then walks the bucket chain entry by entry, and an add copies the name character by
// character. One result item leaves per name. The front holds two name buffers, so one name
// can stream in while the previous one is looked up. After reset a clearing pass empties
// every bucket head before any item is taken.
module name_hash_table_engine #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int HASH_BUCKETS = 256,
    parameter int NAME_CHARS = 64,
    localparam int EW = $clog2(TABLE_ENTRIES),
    localparam int PW = $clog2(TABLE_ENTRIES + 1),
    localparam int OUT_W = ((3 + EW + PW + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [15:0]      i_s_tdata,   // action[1:0], name_char[9:2], zero fill
    input  wire logic             i_s_tlast,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata    // status[2:0], entry_index, entries_in_use
);
    import nhte_pkg::*;

    localparam int LW = $clog2(NAME_CHARS + 1);
    localparam int CW = $clog2(NAME_CHARS);
    localparam int BW = $clog2(HASH_BUCKETS);
    localparam int JOB_W = 32 + LW + 2 + 1 + 1;

    t_ctl             ctl;
    logic             push;
    logic [JOB_W-1:0] job;
    logic             pop;
    logic             job_valid;
    logic [JOB_W-1:0] job_q;
    logic             rd_bank;
    logic [CW-1:0]    rd_idx;
    logic [7:0]       rd_data;

    nhte_front #(
        .NAME_CHARS(NAME_CHARS), .LW(LW), .CW(CW), .JOB_W(JOB_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .i_ctl(ctl), .o_push(push), .o_job(job),
        .i_rd_bank(rd_bank), .i_rd_idx(rd_idx), .o_rd_data(rd_data)
    );

    nhte_queue #(.W(JOB_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(job), .i_pop(pop),
        .o_valid(job_valid), .o_data(job_q)
    );

    nhte_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BUCKETS(HASH_BUCKETS),
        .NAME_CHARS(NAME_CHARS), .LW(LW), .CW(CW), .EW(EW), .PW(PW), .BW(BW),
        .JOB_W(JOB_W), .OUT_W(OUT_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job_q), .o_pop(pop), .o_ctl(ctl),
        .o_rd_bank(rd_bank), .o_rd_idx(rd_idx), .i_rd_data(rd_data),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

endmodule
`default_nettype wire

/* hw/rtl/nhte_queue.sv */
// nhte_queue: two-deep job queue between the front and the back
// depends on nothing
`default_nettype none
module nhte_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_slot [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

endmodule
`default_nettype wire

/* hw/rtl/nhte_front.sv */
// nhte_front: takes name characters, folds and hashes them, buffers the name in two banks
// depends on nhte_pkg
`default_nettype none
module nhte_front #(
    parameter int NAME_CHARS = 64,
    parameter int LW = 7,
    parameter int CW = 6,
    parameter int JOB_W = 43
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [15:0]   i_s_tdata,
    input  wire logic          i_s_tlast,
    input  wire nhte_pkg::t_ctl i_ctl,
    output logic               o_push,
    output logic [JOB_W-1:0]   o_job,
    input  wire logic          i_rd_bank,
    input  wire logic [CW-1:0] i_rd_idx,
    output logic [7:0]         o_rd_data
);
    import nhte_pkg::*;

    logic [7:0]    r_name [2][NAME_CHARS];
    logic [31:0]   r_hash;
    logic [LW-1:0] r_len;
    logic          r_over;
    logic          r_wbank;
    logic [1:0]    r_inflight;

    logic          accept;
    logic          room;
    logic [1:0]    action;
    logic [7:0]    name_char;
    logic [31:0]   n_hash;
    logic [LW-1:0] n_len;
    logic          n_over;

    assign action     = i_s_tdata[1:0];
    assign name_char  = i_s_tdata[9:2];
    assign o_s_tready = (r_inflight != 2'd2) && !i_ctl.clearing;
    assign accept     = i_s_tvalid && o_s_tready;
    assign room       = r_len < LW'(NAME_CHARS);
    assign n_hash     = ((r_hash << 5) + r_hash) ^ {24'd0, fold_char(name_char)};
    assign n_len      = room ? r_len + LW'(1) : r_len;
    assign n_over     = r_over || !room;
    assign o_push     = accept && i_s_tlast;
    assign o_job      = {r_wbank, n_over, action, n_len, n_hash};

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_name[r_wbank][r_len[CW-1:0]] <= name_char;
        end
        o_rd_data <= r_name[i_rd_bank][i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= HASH_SEED;
            r_len      <= '0;
            r_over     <= 1'b0;
            r_wbank    <= 1'b0;
            r_inflight <= 2'd0;
        end else begin
            if (accept) begin
                if (i_s_tlast) begin
                    r_hash  <= HASH_SEED;
                    r_len   <= '0;
                    r_over  <= 1'b0;
                    r_wbank <= ~r_wbank;
                end else begin
                    r_hash <= n_hash;
                    r_len  <= n_len;
                    r_over <= n_over;
                end
            end
            r_inflight <= r_inflight + {1'b0, o_push} - {1'b0, i_ctl.done};
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/nhte_back.sv */
// nhte_back: bucket reduction, chain walk with name compare, add and remove, result register
// depends on nhte_pkg; reads the name banks held in nhte_front
`default_nettype none
module nhte_back #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int HASH_BUCKETS = 256,
    parameter int NAME_CHARS = 64,
    parameter int LW = 7,
    parameter int CW = 6,
    parameter int EW = 10,
    parameter int PW = 11,
    parameter int BW = 8,
    parameter int JOB_W = 43,
    parameter int OUT_W = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire logic [JOB_W-1:0] i_job,
    output logic               o_pop,
    output nhte_pkg::t_ctl     o_ctl,
    output logic               o_rd_bank,
    output logic [CW-1:0]      o_rd_idx,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata
);
    import nhte_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_FIRST  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_LEN    = 4'd6;
    localparam logic [3:0] S_CRD    = 4'd7;
    localparam logic [3:0] S_CCHK   = 4'd8;
    localparam logic [3:0] S_DECIDE = 4'd9;
    localparam logic [3:0] S_CPRD   = 4'd10;
    localparam logic [3:0] S_CPWR   = 4'd11;
    localparam logic [3:0] S_LINK   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam logic [PW-1:0] EMPTY = PW'(TABLE_ENTRIES);

    // byte-wise remainder by reciprocal multiplication
    localparam int XW = BW + 8;
    localparam int MW = 31;
    localparam int RK = 34;
    localparam int QW = 8;
    localparam logic [MW-1:0] RMUL = MW'((64'd1 << RK) / HASH_BUCKETS + 1);

    logic [PW-1:0] m_head  [HASH_BUCKETS];
    logic [PW-1:0] m_link  [TABLE_ENTRIES];
    logic [PW-1:0] m_flink [TABLE_ENTRIES];
    logic [LW-1:0] m_slen  [TABLE_ENTRIES];
    logic [7:0]    m_names [TABLE_ENTRIES][NAME_CHARS];

    logic [3:0]    r_state;
    logic [BW-1:0] r_clr;
    logic [31:0]   r_hash;
    logic [LW-1:0] r_len;
    logic [1:0]    r_act;
    logic          r_over;
    logic          r_bank;
    logic [BW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [4:0]    r_cnt;
    logic [BW-1:0] r_bucket;
    logic [PW-1:0] r_headv;
    logic [PW-1:0] r_e;
    logic [PW-1:0] r_prev;
    logic [PW-1:0] r_next;
    logic [PW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic          r_found;
    logic [PW-1:0] r_free;
    logic [PW-1:0] r_fill;
    logic [PW-1:0] r_count;
    logic [2:0]    r_rstat;
    logic [EW-1:0] r_ridx;
    logic          r_ov;
    logic [OUT_W-1:0] r_odata;

    logic [PW-1:0] r_head_q;
    logic [PW-1:0] r_link_q;
    logic [PW-1:0] r_flink_q;
    logic [LW-1:0] r_slen_q;
    logic [7:0]    r_name_q;

    logic [XW-1:0]    mod_x;
    logic [XW+MW-1:0] mod_p;
    logic [QW-1:0]    mod_q;
    logic [XW-1:0]    mod_r;
    logic [BW-1:0]    n_rem;
    logic          char_last;
    logic          full;
    logic          out_fire;

    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic          link_we;
    logic [EW-1:0] link_wa;
    logic [PW-1:0] link_wd;
    logic          flink_we;
    logic          slen_we;
    logic          name_we;

    assign mod_x = {r_rem, r_hash[31:24]};
    assign mod_p = (XW+MW)'(mod_x) * (XW+MW)'(RMUL);
    assign mod_q = mod_p[RK +: QW];
    assign mod_r = mod_x - XW'(r_q) * XW'(HASH_BUCKETS);
    assign n_rem = mod_r[BW-1:0];
    assign char_last = (LW'(r_i) + LW'(1)) == r_len;
    assign full = (r_count >= EMPTY) || (r_free >= EMPTY);
    assign out_fire = (r_state == S_OUT) && (!r_ov || i_m_tready);

    assign o_pop        = (r_state == S_IDLE) && i_job_valid;
    assign o_ctl.clearing = (r_state == S_CLEAR);
    assign o_ctl.done     = out_fire;
    assign o_rd_bank    = r_bank;
    assign o_rd_idx     = r_i;
    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_odata;

    always_comb begin
        head_we  = 1'b0;
        head_wa  = r_bucket;
        head_wd  = r_n;
        link_we  = 1'b0;
        link_wa  = r_n[EW-1:0];
        link_wd  = r_headv;
        flink_we = 1'b0;
        slen_we  = 1'b0;
        name_we  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = EMPTY;
            end
            S_DECIDE: begin
                if (r_found && r_act == ACT_REMOVE) begin
                    flink_we = 1'b1;
                    if (r_prev == EMPTY) begin
                        head_we = 1'b1;
                        head_wd = r_next;
                    end else begin
                        link_we = 1'b1;
                        link_wa = r_prev[EW-1:0];
                        link_wd = r_next;
                    end
                end
            end
            S_CPWR: name_we = 1'b1;
            S_LINK: begin
                head_we = 1'b1;
                link_we = 1'b1;
                slen_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[head_wa] <= head_wd;
        end
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        if (flink_we) begin
            m_flink[r_e[EW-1:0]] <= r_free;
        end
        if (slen_we) begin
            m_slen[r_n[EW-1:0]] <= r_len;
        end
        if (name_we) begin
            m_names[r_n[EW-1:0]][r_i] <= i_rd_data;
        end
        r_head_q  <= m_head[r_bucket];
        r_link_q  <= m_link[r_e[EW-1:0]];
        r_slen_q  <= m_slen[r_e[EW-1:0]];
        r_flink_q <= m_flink[r_free[EW-1:0]];
        r_name_q  <= m_names[r_e[EW-1:0]][r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(HASH_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        {r_bank, r_over, r_act, r_len, r_hash} <= i_job;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_over) begin
                        r_rstat <= ST_TOO_LONG;
                        r_ridx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                        if (!r_cnt[0]) begin
                            r_q <= mod_q;
                        end else begin
                            r_rem  <= n_rem;
                            r_hash <= r_hash << 8;
                            if (r_cnt == 5'd7) begin
                                r_bucket <= n_rem;
                                r_state  <= S_HEAD;
                            end
                        end
                    end
                end
                S_HEAD: r_state <= S_FIRST;
                S_FIRST: begin
                    r_headv <= r_head_q;
                    r_e     <= r_head_q;
                    r_prev  <= EMPTY;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_e == EMPTY) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_next <= r_link_q;
                    if (r_slen_q != r_len) begin
                        r_prev  <= r_e;
                        r_e     <= r_link_q;
                        r_state <= S_WALK;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_CRD;
                    end
                end
                S_CRD: r_state <= S_CCHK;
                S_CCHK: begin
                    if (fold_char(r_name_q) != fold_char(i_rd_data)) begin
                        r_prev  <= r_e;
                        r_e     <= r_next;
                        r_state <= S_WALK;
                    end else if (char_last) begin
                        r_found <= 1'b1;
                        r_state <= S_DECIDE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_OUT;
                    r_rstat <= ST_NOT_FOUND;
                    r_ridx  <= '0;
                    if (r_found) begin
                        r_ridx <= r_e[EW-1:0];
                        if (r_act == ACT_REMOVE) begin
                            r_rstat <= ST_REMOVED;
                            r_free  <= r_e;
                            if (r_count != '0) begin
                                r_count <= r_count - PW'(1);
                            end
                        end else begin
                            r_rstat <= ST_FOUND;
                        end
                    end else if (r_act == ACT_ADD) begin
                        if (full) begin
                            r_rstat <= ST_FULL;
                        end else begin
                            r_n     <= r_free;
                            r_i     <= '0;
                            r_state <= S_CPRD;
                            if (r_free == r_fill) begin
                                r_free <= r_fill + PW'(1);
                                r_fill <= r_fill + PW'(1);
                            end else begin
                                r_free <= r_flink_q;
                            end
                        end
                    end
                end
                S_CPRD: r_state <= S_CPWR;
                S_CPWR: begin
                    if (char_last) begin
                        r_state <= S_LINK;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_CPRD;
                    end
                end
                S_LINK: begin
                    r_count <= r_count + PW'(1);
                    r_rstat <= ST_ADDED;
                    r_ridx  <= r_n[EW-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_fire) begin
                        r_ov    <= 1'b1;
                        r_odata <= OUT_W'({r_count, r_ridx, r_rstat});
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EMPTY)
        else $error("occupied count above table size");

    a_add_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_count < EMPTY && r_n < EMPTY))
        else $error("entry added to a full table");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= EMPTY) && (r_count <= r_fill))
        else $error("free list watermark inconsistent");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |=> (r_ov && r_state == S_IDLE))
        else $error("result not registered on completion");

endmodule
`default_nettype wire
